@@ src/drd_pkg.sv @@
// Shared types, widths and helpers for the detection row decoder.
// Used by drd_row_acc, drd_axis_clamp and detection_row_decode.
`timescale 1ns / 1ps
`default_nettype none

package drd_pkg;

    localparam int VALUE_W    = 16;
    localparam int POS_W      = 8;
    localparam int CLASS_W    = 7;
    localparam int ROW_W      = 15;
    localparam int FRAME_W    = 13;
    localparam int SUM_W      = 19;                 // 2*c +/- s, signed
    localparam int PROD_W     = SUM_W + FRAME_W + 1; // sum times frame, signed
    localparam int EDGE_W     = PROD_W - 16;         // after the /2^16 step
    localparam int SCORE_P_W  = 2 * VALUE_W;
    localparam int LEFT_W     = 12;
    localparam int EXT_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_W      = ROW_W + CLASS_W + VALUE_W + 2 * LEFT_W + 2 * EXT_W;

    // element positions within a row
    localparam logic [POS_W-1:0] POS_CX     = 8'd0;
    localparam logic [POS_W-1:0] POS_CY     = 8'd1;
    localparam logic [POS_W-1:0] POS_W_EL   = 8'd2;
    localparam logic [POS_W-1:0] POS_H_EL   = 8'd3;
    localparam logic [POS_W-1:0] POS_OBJ    = 8'd4;
    localparam logic [POS_W-1:0] CLASS_BASE = 8'd5;
    localparam logic [POS_W-1:0] CLASS_END  = 8'd133;  // first class base + 128
    localparam logic [POS_W-1:0] POS_MAX    = 8'd255;

    localparam logic [ROW_W-1:0] ROW_LIMIT  = 15'd32767;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_W   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_H   = 2'd2;

    typedef struct packed {
        logic [ROW_W-1:0]   row_index;
        logic [CLASS_W-1:0] class_id;
        logic [VALUE_W-1:0] objectness;
        logic [VALUE_W-1:0] best_prob;
        logic [SUM_W-1:0]   sum_x_lo;   // 2*cx - w
        logic [SUM_W-1:0]   sum_x_hi;   // 2*cx + w
        logic [SUM_W-1:0]   sum_y_lo;
        logic [SUM_W-1:0]   sum_y_hi;
    } t_row_snap;

    // truncation toward zero of p / 2^16
    function automatic logic signed [EDGE_W-1:0] trunc16(input logic signed [PROD_W-1:0] p);
        logic signed [EDGE_W-1:0] q;
        q = p[PROD_W-1:16];
        if (p[PROD_W-1] && (p[15:0] != 16'd0)) begin
            q = q + EDGE_W'(1);
        end
        return q;
    endfunction

endpackage

`default_nettype wire

@@ src/detection_row_decode.sv @@
// Detection row decoder top level: element stream in, one result per kept row out.
// Depends on drd_pkg, drd_row_acc and drd_axis_clamp.
//
// Takes one tensor element per clock cycle while s_axis_tready is high. The
// element that carries tlast closes its row; the row then runs through three
// pipeline registers (row snapshot, products, edge truncation and score test)
// into the output register, where a kept row is presented. Rows that fail the
// threshold tests leave no result. The sustained rate is set by the row
// accumulator, which folds one element into the class maximum each cycle that
// an element is accepted. Each stage moves whenever the next one is free, so
// input keeps flowing while a result waits at the output, until the stages fill.
// Configuration writes are meant to happen only with the pipeline empty.
`timescale 1ns / 1ps
`default_nettype none

module detection_row_decode
    import drd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [VALUE_W-1:0]   i_cfg_data,

    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [VALUE_W-1:0]   s_axis_tdata,   // value
    input  wire logic                 s_axis_tlast,   // row_end
    input  wire logic                 s_axis_tuser,   // frame_start

    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // row_index, class_id, score, box_left, box_top, box_width, box_height
    output logic [OUT_W-1:0]          m_axis_tdata
);

    logic [VALUE_W-1:0] r_thr;
    logic [FRAME_W-1:0] r_frame_w;
    logic [FRAME_W-1:0] r_frame_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= 16'd16384;
            r_frame_w <= 13'd640;
            r_frame_h <= 13'd640;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_thr     <= i_cfg_data;
                CFG_FRAME_W:   r_frame_w <= i_cfg_data[FRAME_W-1:0];
                CFG_FRAME_H:   r_frame_h <= i_cfg_data[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    // stage enables, back to front
    logic en1, en2, en3, en_out;
    logic in_xfer;

    logic r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;

    assign en_out = !r_out_valid || m_axis_tready;
    assign en3    = !r_s3_valid || en_out;
    assign en2    = !r_s2_valid || en3;
    assign en1    = !r_s1_valid || en2;

    assign s_axis_tready = en1;
    assign in_xfer       = s_axis_tvalid && en1;

    t_row_snap snap;
    t_row_snap r_s1;

    drd_row_acc u_acc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_xfer),
        .i_value       (s_axis_tdata),
        .i_row_end     (s_axis_tlast),
        .i_frame_start (s_axis_tuser),
        .o_snap        (snap)
    );

    // stage 1: row snapshot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= in_xfer && s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && in_xfer && s_axis_tlast) begin
            r_s1 <= snap;
        end
    end

    // stage 2: score product and edge products
    logic [ROW_W-1:0]          r_s2_row;
    logic [CLASS_W-1:0]        r_s2_cls;
    logic [VALUE_W-1:0]        r_s2_obj;
    logic [SCORE_P_W-1:0]      r_s2_prod;
    logic signed [PROD_W-1:0]  r_s2_xlo, r_s2_xhi, r_s2_ylo, r_s2_yhi;

    logic signed [FRAME_W:0]   fw_s, fh_s;
    assign fw_s = $signed({1'b0, r_frame_w});
    assign fh_s = $signed({1'b0, r_frame_h});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_row  <= r_s1.row_index;
            r_s2_cls  <= r_s1.class_id;
            r_s2_obj  <= r_s1.objectness;
            r_s2_prod <= r_s1.objectness * r_s1.best_prob;
            r_s2_xlo  <= $signed(r_s1.sum_x_lo) * fw_s;
            r_s2_xhi  <= $signed(r_s1.sum_x_hi) * fw_s;
            r_s2_ylo  <= $signed(r_s1.sum_y_lo) * fh_s;
            r_s2_yhi  <= $signed(r_s1.sum_y_hi) * fh_s;
        end
    end

    // stage 3: threshold tests, score, truncated edges
    logic                     keep;
    logic [SCORE_P_W-16:0]    score_full;
    logic [VALUE_W-1:0]       score_sat;

    assign keep = (r_s2_obj > r_thr) &&
                  (r_s2_prod > {1'b0, r_thr, 15'd0});
    assign score_full = r_s2_prod[SCORE_P_W-1:15];
    assign score_sat  = score_full[SCORE_P_W-16] ? {VALUE_W{1'b1}}
                                                 : score_full[VALUE_W-1:0];

    logic [ROW_W-1:0]          r_s3_row;
    logic [CLASS_W-1:0]        r_s3_cls;
    logic [VALUE_W-1:0]        r_s3_score;
    logic signed [EDGE_W-1:0]  r_s3_xlo, r_s3_xhi, r_s3_ylo, r_s3_yhi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en3) begin
            r_s3_valid <= r_s2_valid && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_row   <= r_s2_row;
            r_s3_cls   <= r_s2_cls;
            r_s3_score <= score_sat;
            r_s3_xlo   <= trunc16(r_s2_xlo);
            r_s3_xhi   <= trunc16(r_s2_xhi);
            r_s3_ylo   <= trunc16(r_s2_ylo);
            r_s3_yhi   <= trunc16(r_s2_yhi);
        end
    end

    // output stage: clamp to the frame
    logic [LEFT_W-1:0]        left, top;
    logic signed [EXT_W-1:0]  bw, bh;

    drd_axis_clamp u_clamp_x (
        .i_lo    (r_s3_xlo),
        .i_hi    (r_s3_xhi),
        .i_frame (r_frame_w),
        .o_low   (left),
        .o_ext   (bw)
    );

    drd_axis_clamp u_clamp_y (
        .i_lo    (r_s3_ylo),
        .i_hi    (r_s3_yhi),
        .i_frame (r_frame_h),
        .o_low   (top),
        .o_ext   (bh)
    );

    logic [OUT_W-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out <= {bh, bw, top, left, r_s3_score, r_s3_cls, r_s3_row};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // a row snapshot appears only after a transfer that closed a row
    a_snap_from_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_s1_valid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
        else $error("row snapshot without a row end transfer");

    // a blocked snapshot is not lost
    a_snap_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !en2) |=> r_s1_valid)
        else $error("stalled row snapshot dropped");

    // a presented result always passed the score test
    a_score_over_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[37:22] >= r_thr))
        else $error("result score below threshold");

    // the input side never stalls while stage 1 or stage 2 is free
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_s1_valid || !r_s2_valid) |-> s_axis_tready)
        else $error("input stalled with a free stage");

endmodule

`default_nettype wire

@@ src/drd_row_acc.sv @@
// Per-row accumulator: holds box fields, objectness and the running class maximum.
// Presents the finished row snapshot for the element being accepted. Uses drd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drd_row_acc
    import drd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic               i_row_end,
    input  wire logic               i_frame_start,
    output t_row_snap               o_snap
);

    logic [POS_W-1:0]   r_pos,  n_pos;
    logic [VALUE_W-1:0] r_cx,   n_cx;
    logic [VALUE_W-1:0] r_cy,   n_cy;
    logic [VALUE_W-1:0] r_w,    n_w;
    logic [VALUE_W-1:0] r_h,    n_h;
    logic [VALUE_W-1:0] r_obj,  n_obj;
    logic [VALUE_W-1:0] r_best, n_best;
    logic [CLASS_W-1:0] r_cls,  n_cls;
    logic [ROW_W-1:0]   r_row,  n_row;

    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] cx, cy, w, h, obj, best;
    logic [CLASS_W-1:0] cls;
    logic [ROW_W-1:0]   row;
    logic [POS_W-1:0]   class_off;

    always_comb begin
        // frame start clears everything before the element lands
        pos  = i_frame_start ? '0 : r_pos;
        cx   = i_frame_start ? '0 : r_cx;
        cy   = i_frame_start ? '0 : r_cy;
        w    = i_frame_start ? '0 : r_w;
        h    = i_frame_start ? '0 : r_h;
        obj  = i_frame_start ? '0 : r_obj;
        best = i_frame_start ? '0 : r_best;
        cls  = i_frame_start ? '0 : r_cls;
        row  = i_frame_start ? '0 : r_row;
        class_off = pos - CLASS_BASE;

        case (pos)
            POS_CX:   cx  = i_value;
            POS_CY:   cy  = i_value;
            POS_W_EL: w   = i_value;
            POS_H_EL: h   = i_value;
            POS_OBJ:  obj = i_value;
            default: begin
                if ((pos < CLASS_END) && (i_value > best)) begin
                    best = i_value;
                    cls  = class_off[CLASS_W-1:0];
                end
            end
        endcase

        o_snap.row_index  = row;
        o_snap.class_id   = cls;
        o_snap.objectness = obj;
        o_snap.best_prob  = best;
        o_snap.sum_x_lo   = {2'b00, cx, 1'b0} - {3'b000, w};
        o_snap.sum_x_hi   = {2'b00, cx, 1'b0} + {3'b000, w};
        o_snap.sum_y_lo   = {2'b00, cy, 1'b0} - {3'b000, h};
        o_snap.sum_y_hi   = {2'b00, cy, 1'b0} + {3'b000, h};

        n_pos = r_pos; n_cx = r_cx; n_cy = r_cy; n_w = r_w; n_h = r_h;
        n_obj = r_obj; n_best = r_best; n_cls = r_cls; n_row = r_row;
        if (i_accept) begin
            if (i_row_end) begin
                n_pos = '0; n_cx = '0; n_cy = '0; n_w = '0; n_h = '0;
                n_obj = '0; n_best = '0; n_cls = '0;
                n_row = (row < ROW_LIMIT) ? row + ROW_W'(1) : row;
            end else begin
                n_pos = (pos < POS_MAX) ? pos + POS_W'(1) : pos;
                n_cx = cx; n_cy = cy; n_w = w; n_h = h;
                n_obj = obj; n_best = best; n_cls = cls; n_row = row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_cx <= '0; r_cy <= '0; r_w <= '0; r_h <= '0;
            r_obj <= '0; r_best <= '0; r_cls <= '0; r_row <= '0;
        end else begin
            r_pos <= n_pos; r_cx <= n_cx; r_cy <= n_cy; r_w <= n_w; r_h <= n_h;
            r_obj <= n_obj; r_best <= n_best; r_cls <= n_cls; r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

@@ src/drd_axis_clamp.sv @@
// One box axis: clamps the low and high edges to the frame and forms the extent.
// Combinational; uses drd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drd_axis_clamp
    import drd_pkg::*;
(
    input  wire logic signed [EDGE_W-1:0]  i_lo,
    input  wire logic signed [EDGE_W-1:0]  i_hi,
    input  wire logic        [FRAME_W-1:0] i_frame,
    output logic             [LEFT_W-1:0]  o_low,
    output logic signed      [EXT_W-1:0]   o_ext
);

    localparam logic signed [EDGE_W:0] EXT_MAX = (EDGE_W + 1)'(4095);
    localparam logic signed [EDGE_W:0] EXT_MIN = -(EDGE_W + 1)'(4096);
    localparam logic signed [EDGE_W-1:0] LOW_MAX = EDGE_W'(4095);

    logic signed [EDGE_W-1:0] frame_m1;
    logic signed [EDGE_W-1:0] lo_c;
    logic signed [EDGE_W-1:0] hi_c;
    logic signed [EDGE_W:0]   ext;

    always_comb begin
        frame_m1 = $signed({{(EDGE_W - FRAME_W){1'b0}}, i_frame}) - EDGE_W'(1);
        lo_c = (i_lo < 0) ? '0 : i_lo;
        hi_c = (i_hi > frame_m1) ? frame_m1 : i_hi;
        ext  = $signed({hi_c[EDGE_W-1], hi_c}) - $signed({lo_c[EDGE_W-1], lo_c});

        o_low = (lo_c > LOW_MAX) ? LOW_MAX[LEFT_W-1:0] : lo_c[LEFT_W-1:0];
        if (ext > EXT_MAX) begin
            o_ext = EXT_MAX[EXT_W-1:0];
        end else if (ext < EXT_MIN) begin
            o_ext = EXT_MIN[EXT_W-1:0];
        end else begin
            o_ext = ext[EXT_W-1:0];
        end
    end

endmodule

`default_nettype wire
